>>> hdl/assert_macros.svh
// Assertion macros shared by the display slave RTL.
// Included by every module that carries concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define MRDS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("modbus display slave: assertion failed");
// Checked on every clock edge, reset included.
`define MRDS_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("modbus display slave: assertion failed");
`else
`define MRDS_ASSERT(label, clk, rst_n, prop)
`define MRDS_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> hdl/mrds_pkg.sv
// Package of the Modbus RTU display slave: item types, frame constants,
// the CRC-16 byte step and the segment code table. No dependencies.
`timescale 1ns / 1ps
package mrds_pkg;

	localparam int FRAME_CAPACITY_DEF = 32;

	// Input item kinds.
	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_GAP  = 1'b1;

	// Result item kinds.
	localparam logic KIND_DIGIT = 1'b0;
	localparam logic KIND_REPLY = 1'b1;

	// Modbus function codes and fixed frame bytes.
	localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] FUNC_READ_INPUTS = 8'h02;
	localparam logic [7:0] WR_QTY_LO        = 8'h08;
	localparam logic [7:0] WR_BYTE_COUNT    = 8'h10;
	localparam logic [7:0] RD_QTY_LO        = 8'h01;
	localparam logic [7:0] RD_BYTE_COUNT    = 8'h01;

	localparam int WRITE_LEN   = 25;
	localparam int READ_LEN    = 8;
	localparam int DATA_FIRST  = 7;
	localparam int DATA_BYTES  = 16;
	localparam int WR_MSG_LEN  = 6;
	localparam int RD_MSG_LEN  = 4;

	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [15:0] CRC_POLY   = 16'hA001;
	localparam logic [7:0]  SEG_ALL_ON = 8'hFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = 1;
	localparam int QUEUE_CNT_W = 2;

	typedef struct packed {
		logic       func;
		logic [7:0] rx_byte;
		logic [2:0] buttons;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [2:0] digit_index;
		logic [7:0] digit_segments;
		logic       digit_blink;
		logic [7:0] tx_byte;
		logic       last;
	} out_item_t;

	// One checked frame handed from the front to the back.
	typedef struct packed {
		logic                       is_write;
		logic [7:0]                 addr;
		logic [2:0]                 buttons;
		logic [DATA_BYTES-1:0][7:0] data;
	} frame_desc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_status_t;

	// One byte of the reflected Modbus CRC-16.
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
		input logic [7:0] data);
		logic [15:0] c;
		c = crc_in ^ {8'h00, data};
		for (int b = 0; b < 8; b++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

	// Hex digits, then P; anything else lights every segment.
	function automatic logic [7:0] seg_code(input logic [7:0] v);
		logic [7:0] s;
		case (v)
			8'd0:    s = 8'hFC;
			8'd1:    s = 8'h60;
			8'd2:    s = 8'hD9;
			8'd3:    s = 8'hF1;
			8'd4:    s = 8'h65;
			8'd5:    s = 8'hB5;
			8'd6:    s = 8'hBD;
			8'd7:    s = 8'hE0;
			8'd8:    s = 8'hFD;
			8'd9:    s = 8'hF5;
			8'd10:   s = 8'hED;
			8'd11:   s = 8'h3D;
			8'd12:   s = 8'h9C;
			8'd13:   s = 8'h79;
			8'd14:   s = 8'h9D;
			8'd15:   s = 8'h8D;
			8'd16:   s = 8'hCD;
			default: s = SEG_ALL_ON;
		endcase
		return s;
	endfunction

endpackage

>>> hdl/modbus_rtu_display_slave.sv
// Top level of the Modbus RTU display slave: receive side, descriptor queue
// and reply side. Uses mrds_pkg, mrds_front, mrds_queue and mrds_back.
`timescale 1ns / 1ps
// Modbus RTU slave for an eight-digit display. Each input item is either a
// received byte or a frame gap. A received byte is stored, folded into the
// running CRC-16 and checked against the fixed header bytes on arrival, so at
// a frame gap the frame is judged from those running results and, if it is a
// good write (0x10) or read (0x02) frame for device_address, a descriptor goes
// into a two-entry queue. The reply side drains that queue and puts out one
// result item per cycle while the output is taken, through its output
// register: a write frame gives eight digit updates (digit 7 first) and an
// 8-byte reply, 16 items in all, a read frame a 6-byte reply; last marks the
// final item of each frame. A frame's descriptor passes through the queue and
// the reply side's descriptor register before its first result item is
// registered at the output, and the output idles between frames while the
// next descriptor is taken from the queue. Input items stall only while the
// queue holds two frames not yet started, so the sustained rate is set by the
// reply side. device_address is written on the cfg channel, which is always
// ready, and resets to 1.
module modbus_rtu_display_slave #(
	parameter int FRAME_CAPACITY = mrds_pkg::FRAME_CAPACITY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  mrds_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output mrds_pkg::out_item_t out_item
);

	logic [7:0] device_address_q;

	logic                    push;
	logic                    pop;
	mrds_pkg::frame_desc_t   push_desc;
	mrds_pkg::frame_desc_t   head_desc;
	mrds_pkg::queue_status_t q_status;

	// The address register is a plain write port with no wait states.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= 8'h01;
		end else if (cfg_valid && cfg_ready) begin
			device_address_q <= cfg_data;
		end
	end

	// Receive side: byte collection, CRC and header checks, frame verdict.
	mrds_front #(
		.FRAME_CAPACITY(FRAME_CAPACITY)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.device_address (device_address_q),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_item        (in_item),
		.q_status       (q_status),
		.push           (push),
		.push_desc      (push_desc)
	);

	// Accepted frames wait here so the receive side can take the next frame
	// while a reply is still going out.
	mrds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.status    (q_status)
	);

	// Reply side: digit updates, then reply bytes with their CRC.
	mrds_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_desc (head_desc),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> hdl/mrds_front.sv
// Receive side: collects frame bytes, runs the CRC and header checks per byte
// and, at a frame gap, queues a descriptor of an accepted frame. Uses mrds_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrds_front #(
	parameter int FRAME_CAPACITY = mrds_pkg::FRAME_CAPACITY_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            device_address,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  mrds_pkg::in_item_t    in_item,
	input  mrds_pkg::queue_status_t q_status,
	output logic                  push,
	output mrds_pkg::frame_desc_t push_desc
);

	localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

	logic [CNT_W-1:0] count_q;
	logic [15:0]      crc_q;
	logic [7:0]       addr_q;
	logic [7:0]       fcode_q;
	logic             wr_fix_q;
	logic             rd_fix_q;
	logic [7:0]       data_q [mrds_pkg::DATA_BYTES];

	logic             accept;
	logic             take_byte;
	logic [CNT_W-1:0] rel;
	logic [3:0]       data_idx;
	logic             in_data;
	logic             frame_ok;
	logic             is_write;
	logic             is_read;

	assign in_ready  = !q_status.full;
	assign accept    = in_valid && in_ready;
	assign take_byte = accept && (in_item.func == mrds_pkg::FUNC_BYTE);

	assign rel      = count_q - CNT_W'(mrds_pkg::DATA_FIRST);
	assign data_idx = rel[3:0];
	assign in_data  = (count_q >= CNT_W'(mrds_pkg::DATA_FIRST)) &&
		(count_q < CNT_W'(mrds_pkg::DATA_FIRST + mrds_pkg::DATA_BYTES));

	// Counter, running CRC and header flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (in_item.func == mrds_pkg::FUNC_GAP) begin
				count_q <= '0;
			end else if (count_q == CNT_W'(FRAME_CAPACITY)) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte && (count_q != CNT_W'(FRAME_CAPACITY))) begin
			if (count_q == '0) begin
				crc_q    <= mrds_pkg::crc16_byte(mrds_pkg::CRC_PRESET, in_item.rx_byte);
				addr_q   <= in_item.rx_byte;
				wr_fix_q <= 1'b1;
				rd_fix_q <= 1'b1;
			end else begin
				crc_q <= mrds_pkg::crc16_byte(crc_q, in_item.rx_byte);
				if (count_q == CNT_W'(1)) begin
					fcode_q <= in_item.rx_byte;
				end
				if ((count_q == CNT_W'(2)) || (count_q == CNT_W'(3)) ||
					(count_q == CNT_W'(4))) begin
					wr_fix_q <= wr_fix_q && (in_item.rx_byte == 8'h00);
					rd_fix_q <= rd_fix_q && (in_item.rx_byte == 8'h00);
				end
				if (count_q == CNT_W'(5)) begin
					wr_fix_q <= wr_fix_q && (in_item.rx_byte == mrds_pkg::WR_QTY_LO);
					rd_fix_q <= rd_fix_q && (in_item.rx_byte == mrds_pkg::RD_QTY_LO);
				end
				if (count_q == CNT_W'(6)) begin
					wr_fix_q <= wr_fix_q && (in_item.rx_byte == mrds_pkg::WR_BYTE_COUNT);
				end
			end
			if (in_data) begin
				data_q[data_idx] <= in_item.rx_byte;
			end
		end
	end

	assign is_write = (fcode_q == mrds_pkg::FUNC_WRITE_MULTI) &&
		(count_q == CNT_W'(mrds_pkg::WRITE_LEN)) && wr_fix_q;
	assign is_read  = (fcode_q == mrds_pkg::FUNC_READ_INPUTS) &&
		(count_q == CNT_W'(mrds_pkg::READ_LEN)) && rd_fix_q;
	assign frame_ok = (count_q != '0) && (crc_q == 16'h0000) &&
		(addr_q == device_address) && (is_write || is_read);

	assign push = accept && (in_item.func == mrds_pkg::FUNC_GAP) && frame_ok;

	always_comb begin
		push_desc.is_write = is_write;
		push_desc.addr     = addr_q;
		push_desc.buttons  = in_item.buttons;
		for (int i = 0; i < mrds_pkg::DATA_BYTES; i++) begin
			push_desc.data[i] = data_q[i];
		end
	end

	`MRDS_ASSERT(a_push_nonempty, clk, arst_n, push |-> (count_q != '0))
	`MRDS_ASSERT(a_push_has_room, clk, arst_n, push |-> !q_status.full)

endmodule

>>> hdl/mrds_queue.sv
// Two-entry queue of frame descriptors between the receive and reply sides.
// Uses mrds_pkg for the descriptor type and depth.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrds_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  mrds_pkg::frame_desc_t   push_desc,
	input  logic                    pop,
	output mrds_pkg::frame_desc_t   head_desc,
	output mrds_pkg::queue_status_t status
);

	mrds_pkg::frame_desc_t slot_q [mrds_pkg::QUEUE_DEPTH];
	logic [mrds_pkg::QUEUE_PTR_W-1:0] wptr_q;
	logic [mrds_pkg::QUEUE_PTR_W-1:0] rptr_q;
	logic [mrds_pkg::QUEUE_CNT_W-1:0] cnt_q;

	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == mrds_pkg::QUEUE_CNT_W'(mrds_pkg::QUEUE_DEPTH));
	assign head_desc    = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`MRDS_ASSERT(a_pop_nonempty, clk, arst_n, pop |-> !status.empty)
	`MRDS_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= mrds_pkg::QUEUE_CNT_W'(mrds_pkg::QUEUE_DEPTH))

endmodule

>>> hdl/mrds_back.sv
// Reply side: takes one frame descriptor at a time and emits digit updates
// and the reply bytes with their CRC through an output register. Uses mrds_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mrds_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mrds_pkg::frame_desc_t   head_desc,
	input  mrds_pkg::queue_status_t q_status,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output mrds_pkg::out_item_t     out_item
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_DIGIT = 3'b010,
		ST_REPLY = 3'b100
	} back_state_t;

	back_state_t           state_q;
	mrds_pkg::frame_desc_t desc_q;
	logic [2:0]            step_q;
	logic [15:0]           crc_q;
	logic                  out_valid_q;
	mrds_pkg::out_item_t   out_item_q;

	logic                  adv;
	logic                  emit;
	logic [2:0]            msg_len;
	logic [7:0]            msg_byte;
	logic [7:0]            ctl_byte;
	logic [7:0]            val_byte;
	logic [3:0]            pair;

	assign adv  = !out_valid_q || out_ready;
	assign emit = adv && ((state_q == ST_DIGIT) || (state_q == ST_REPLY));
	assign pop  = (state_q == ST_IDLE) && !q_status.empty;

	assign msg_len = desc_q.is_write ? 3'(mrds_pkg::WR_MSG_LEN) : 3'(mrds_pkg::RD_MSG_LEN);

	// Bytes of the reply before its CRC.
	always_comb begin
		case (step_q)
			3'd0:    msg_byte = desc_q.addr;
			3'd1:    msg_byte = desc_q.is_write ? mrds_pkg::FUNC_WRITE_MULTI
				: mrds_pkg::FUNC_READ_INPUTS;
			3'd2:    msg_byte = desc_q.is_write ? 8'h00 : mrds_pkg::RD_BYTE_COUNT;
			3'd3:    msg_byte = desc_q.is_write ? 8'h00 : {5'b00000, desc_q.buttons};
			default: msg_byte = 8'h00;
		endcase
	end

	// Digits go out from the highest position; each has a control and a value byte.
	assign pair     = {step_q, 1'b0};
	assign ctl_byte = desc_q.data[pair];
	assign val_byte = desc_q.data[pair + 4'd1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= head_desc.is_write ? ST_DIGIT : ST_REPLY;
						step_q  <= '0;
					end
				end
				ST_DIGIT: begin
					if (adv) begin
						step_q <= step_q + 1'b1;
						if (step_q == 3'd7) begin
							state_q <= ST_REPLY;
						end
					end
				end
				ST_REPLY: begin
					if (adv) begin
						if (step_q == msg_len + 3'd1) begin
							state_q <= ST_IDLE;
							step_q  <= '0;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			desc_q <= head_desc;
			crc_q  <= mrds_pkg::CRC_PRESET;
		end
		if (adv && (state_q == ST_DIGIT)) begin
			out_item_q.result_kind    <= mrds_pkg::KIND_DIGIT;
			out_item_q.digit_index    <= 3'd7 - step_q;
			out_item_q.digit_segments <= ctl_byte[0] ? val_byte : mrds_pkg::seg_code(val_byte);
			out_item_q.digit_blink    <= ctl_byte[1];
			out_item_q.tx_byte        <= 8'h00;
			out_item_q.last           <= 1'b0;
		end
		if (adv && (state_q == ST_REPLY)) begin
			out_item_q.result_kind    <= mrds_pkg::KIND_REPLY;
			out_item_q.digit_index    <= 3'd0;
			out_item_q.digit_segments <= 8'h00;
			out_item_q.digit_blink    <= 1'b0;
			out_item_q.last           <= (step_q == msg_len + 3'd1);
			if (step_q < msg_len) begin
				out_item_q.tx_byte <= msg_byte;
				crc_q              <= mrds_pkg::crc16_byte(crc_q, msg_byte);
			end else if (step_q == msg_len) begin
				out_item_q.tx_byte <= crc_q[7:0];
			end else begin
				out_item_q.tx_byte <= crc_q[15:8];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	`MRDS_ASSERT(a_last_on_reply, clk, arst_n,
		(out_valid_q && out_item_q.last) |-> (out_item_q.result_kind == mrds_pkg::KIND_REPLY))
	`MRDS_ASSERT(a_pop_only_idle, clk, arst_n, pop |-> (state_q == ST_IDLE))

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the Modbus RTU display slave.
// Depends on mrds_pkg and modbus_rtu_display_slave; predicts every result item
// from its own model of the frame store, the CRC-16 check and the digit decoding.
`timescale 1ns / 1ps
module testbench;

	localparam int STORE_DEPTH   = mrds_pkg::FRAME_CAPACITY_DEF;
	localparam int CYCLE_LIMIT   = 600000;
	localparam int SETTLE_CYCLES = 32;
	localparam int RANDOM_ITEMS  = 60;
	localparam int MAX_PRINTED   = 40;

	// Segment glyphs for codes 0..15 and P (16), index 0 in the low byte.
	localparam logic [16:0][7:0] GLYPHS = {
		8'hCD, 8'h8D, 8'h9D, 8'h79, 8'h9C, 8'h3D, 8'hED, 8'hF5, 8'hFD,
		8'hE0, 8'hBD, 8'hB5, 8'h65, 8'hF1, 8'hD9, 8'h60, 8'hFC};

	// Ways to spoil a frame so that the slave stays silent (an overflow ends in a good read).
	typedef enum int {
		FLAW_NOISE, FLAW_CRC, FLAW_ADDR, FLAW_FUNC, FLAW_LENGTH, FLAW_FIELD,
		FLAW_OVERFLOW
	} frame_flaw_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [7:0]          cfg_data;
	logic                in_valid;
	logic                in_ready;
	mrds_pkg::in_item_t  in_item;
	logic                out_valid;
	logic                out_ready;
	mrds_pkg::out_item_t out_item;

	modbus_rtu_display_slave dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	// Predicted slave state.
	logic [7:0]  slave_addr;
	logic [7:0]  rx_store [STORE_DEPTH];
	int          rx_count;
	logic [7:0]  shown_segments [8];
	logic        shown_blink [8];

	mrds_pkg::out_item_t pending_results [$];
	mrds_pkg::out_item_t want_item;
	logic [7:0]  reply_bytes [$];
	logic [7:0]  frame_bytes [$];
	logic [7:0]  digit_ctrl [8];
	logic [7:0]  digit_val [8];

	logic        idle_off;
	int          mismatches;
	int          results_checked;
	int          items_sent;
	int          frames_answered;
	int          address_writes;
	int          cycle_count;

	initial begin
		clk = 1'b0;
	end
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic report_mismatch(string what, int want, int got);
		mismatches++;
		if (mismatches <= MAX_PRINTED) begin
			$display("mismatch: %s at result %0d, wanted %0h, saw %0h",
				what, results_checked, want, got);
		end
	endtask

	function automatic int draw_wait();
		return idle_off ? 0 : $urandom_range(0, 6);
	endfunction

	// Reflected CRC-16 fold of one byte.
	function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ mrds_pkg::CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [7:0] glyph_for(logic [7:0] v);
		return (v <= 8'd16) ? GLYPHS[v[4:0]] : mrds_pkg::SEG_ALL_ON;
	endfunction

	// Appends the CRC to reply_bytes and queues the reply as result items.
	task automatic queue_reply();
		logic [15:0]         crc;
		mrds_pkg::out_item_t r;
		crc = mrds_pkg::CRC_PRESET;
		foreach (reply_bytes[i]) begin
			crc = crc_fold(crc, reply_bytes[i]);
		end
		reply_bytes.push_back(crc[7:0]);
		reply_bytes.push_back(crc[15:8]);
		for (int i = 0; i < reply_bytes.size(); i++) begin
			r = '0;
			r.result_kind = mrds_pkg::KIND_REPLY;
			r.tx_byte = reply_bytes[i];
			r.last = (i == reply_bytes.size() - 1);
			pending_results.push_back(r);
		end
		frames_answered++;
	endtask

	// Judges the stored frame at a gap and queues whatever it should cause.
	task automatic judge_frame(logic [2:0] btn);
		logic [15:0]         crc;
		mrds_pkg::out_item_t r;
		logic [7:0]          c;
		logic [7:0]          v;
		int                  pos;
		if (rx_count == 0) return;
		crc = mrds_pkg::CRC_PRESET;
		for (int i = 0; i < rx_count; i++) begin
			crc = crc_fold(crc, rx_store[i]);
		end
		if (crc != 16'h0000 || rx_store[0] != slave_addr) return;
		reply_bytes.delete();
		if (rx_store[1] == mrds_pkg::FUNC_WRITE_MULTI) begin
			if (rx_count != mrds_pkg::WRITE_LEN || rx_store[2] != 8'h00 ||
				rx_store[3] != 8'h00 || rx_store[4] != 8'h00 ||
				rx_store[5] != mrds_pkg::WR_QTY_LO ||
				rx_store[6] != mrds_pkg::WR_BYTE_COUNT) return;
			// Digits go out from 7 down to 0, each from a control and a data byte.
			for (int d = 7; d >= 0; d--) begin
				pos = mrds_pkg::DATA_FIRST + 2 * (7 - d);
				c = rx_store[pos];
				v = rx_store[pos + 1];
				shown_blink[d] = c[1];
				shown_segments[d] = c[0] ? v : glyph_for(v);
				r = '0;
				r.result_kind = mrds_pkg::KIND_DIGIT;
				r.digit_index = 3'(d);
				r.digit_segments = shown_segments[d];
				r.digit_blink = shown_blink[d];
				pending_results.push_back(r);
			end
			// The reply carries zero quantity bytes.
			reply_bytes.push_back(slave_addr);
			reply_bytes.push_back(mrds_pkg::FUNC_WRITE_MULTI);
			repeat (4) reply_bytes.push_back(8'h00);
			queue_reply();
		end else if (rx_store[1] == mrds_pkg::FUNC_READ_INPUTS) begin
			if (rx_count != mrds_pkg::READ_LEN || rx_store[2] != 8'h00 ||
				rx_store[3] != 8'h00 || rx_store[4] != 8'h00 ||
				rx_store[5] != mrds_pkg::RD_QTY_LO) return;
			reply_bytes.push_back(slave_addr);
			reply_bytes.push_back(mrds_pkg::FUNC_READ_INPUTS);
			reply_bytes.push_back(mrds_pkg::RD_BYTE_COUNT);
			reply_bytes.push_back({5'b00000, btn});
			queue_reply();
		end
	endtask

	task automatic track_item(mrds_pkg::in_item_t it);
		if (it.func == mrds_pkg::FUNC_BYTE) begin
			// A byte into a full store clears the count and is dropped.
			if (rx_count >= STORE_DEPTH) begin
				rx_count = 0;
			end else begin
				rx_store[rx_count] = it.rx_byte;
				rx_count++;
			end
		end else begin
			judge_frame(it.buttons);
			rx_count = 0;
		end
	endtask

	// Offers one item after a random hold-off and waits for its acceptance.
	task automatic send_item(mrds_pkg::in_item_t it);
		int w;
		w = draw_wait();
		if (w > 0) begin
			in_valid <= 1'b0;
			repeat (w) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do @(posedge clk); while (!in_ready);
		track_item(it);
		items_sent++;
	endtask

	task automatic send_byte(logic [7:0] b);
		mrds_pkg::in_item_t it;
		it.func = mrds_pkg::FUNC_BYTE;
		it.rx_byte = b;
		it.buttons = 3'($urandom_range(0, 7));
		send_item(it);
	endtask

	task automatic send_gap(logic [2:0] btn);
		mrds_pkg::in_item_t it;
		it.func = mrds_pkg::FUNC_GAP;
		it.rx_byte = 8'($urandom_range(0, 255));
		it.buttons = btn;
		send_item(it);
	endtask

	task automatic send_noise(int n);
		repeat (n) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(logic [2:0] btn);
		foreach (frame_bytes[i]) begin
			send_byte(frame_bytes[i]);
		end
		send_gap(btn);
	endtask

	task automatic start_frame(logic [7:0] addr, logic [7:0] fcode);
		frame_bytes.delete();
		frame_bytes.push_back(addr);
		frame_bytes.push_back(fcode);
	endtask

	task automatic seal_frame();
		logic [15:0] crc;
		crc = mrds_pkg::CRC_PRESET;
		foreach (frame_bytes[i]) begin
			crc = crc_fold(crc, frame_bytes[i]);
		end
		frame_bytes.push_back(crc[7:0]);
		frame_bytes.push_back(crc[15:8]);
	endtask

	task automatic make_read(logic [7:0] addr);
		start_frame(addr, mrds_pkg::FUNC_READ_INPUTS);
		repeat (3) frame_bytes.push_back(8'h00);
		frame_bytes.push_back(mrds_pkg::RD_QTY_LO);
		seal_frame();
	endtask

	task automatic make_write(logic [7:0] addr);
		start_frame(addr, mrds_pkg::FUNC_WRITE_MULTI);
		repeat (3) frame_bytes.push_back(8'h00);
		frame_bytes.push_back(mrds_pkg::WR_QTY_LO);
		frame_bytes.push_back(mrds_pkg::WR_BYTE_COUNT);
		for (int d = 7; d >= 0; d--) begin
			frame_bytes.push_back(digit_ctrl[d]);
			frame_bytes.push_back(digit_val[d]);
		end
		seal_frame();
	endtask

	// Codes near the glyph range are favored so the hex and P glyphs come up often.
	task automatic random_digits();
		for (int d = 0; d < 8; d++) begin
			digit_ctrl[d] = 8'($urandom_range(0, 255));
			digit_val[d] = $urandom_range(0, 1) ? 8'($urandom_range(0, 17))
				: 8'($urandom_range(0, 255));
		end
	endtask

	task automatic send_flawed(frame_flaw_t flaw);
		logic [7:0] fcode;
		int         idx;
		int         n;
		case (flaw)
			FLAW_NOISE: begin
				send_noise($urandom_range(0, 12));
				send_gap(3'($urandom_range(0, 7)));
			end
			FLAW_CRC: begin
				if ($urandom_range(0, 1)) begin
					make_read(slave_addr);
				end else begin
					random_digits();
					make_write(slave_addr);
				end
				idx = $urandom_range(0, frame_bytes.size() - 1);
				frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
				send_frame(3'($urandom_range(0, 7)));
			end
			FLAW_ADDR: begin
				make_read(slave_addr ^ 8'($urandom_range(1, 255)));
				send_frame(3'($urandom_range(0, 7)));
			end
			FLAW_FUNC: begin
				do fcode = 8'($urandom_range(0, 255));
				while (fcode == mrds_pkg::FUNC_WRITE_MULTI ||
					fcode == mrds_pkg::FUNC_READ_INPUTS);
				start_frame(slave_addr, fcode);
				repeat (4) frame_bytes.push_back(8'($urandom_range(0, 255)));
				seal_frame();
				send_frame(3'($urandom_range(0, 7)));
			end
			FLAW_LENGTH: begin
				if ($urandom_range(0, 1)) begin
					// Write header with too few or too many data bytes.
					do n = $urandom_range(0, 20); while (n == mrds_pkg::DATA_BYTES);
					start_frame(slave_addr, mrds_pkg::FUNC_WRITE_MULTI);
					repeat (3) frame_bytes.push_back(8'h00);
					frame_bytes.push_back(mrds_pkg::WR_QTY_LO);
					frame_bytes.push_back(mrds_pkg::WR_BYTE_COUNT);
					repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
				end else begin
					// Read frame carrying one extra byte.
					start_frame(slave_addr, mrds_pkg::FUNC_READ_INPUTS);
					repeat (3) frame_bytes.push_back(8'h00);
					frame_bytes.push_back(mrds_pkg::RD_QTY_LO);
					frame_bytes.push_back(8'($urandom_range(0, 255)));
				end
				seal_frame();
				send_frame(3'($urandom_range(0, 7)));
			end
			FLAW_FIELD: begin
				// One fixed header byte spoiled, CRC recomputed so only that check fails.
				if ($urandom_range(0, 1)) begin
					random_digits();
					make_write(slave_addr);
					idx = $urandom_range(2, 6);
				end else begin
					make_read(slave_addr);
					idx = $urandom_range(2, 5);
				end
				void'(frame_bytes.pop_back());
				void'(frame_bytes.pop_back());
				frame_bytes[idx] = frame_bytes[idx] ^ 8'($urandom_range(1, 255));
				seal_frame();
				send_frame(3'($urandom_range(0, 7)));
			end
			FLAW_OVERFLOW: begin
				// 33 or 66 bytes leave the store empty, so the read that follows is good; other counts may not.
				case ($urandom_range(0, 2))
					0: n = STORE_DEPTH + 1;
					1: n = 2 * (STORE_DEPTH + 1);
					default: n = $urandom_range(STORE_DEPTH + 2, 2 * STORE_DEPTH + 5);
				endcase
				send_noise(n);
				make_read(slave_addr);
				send_frame(3'($urandom_range(0, 7)));
			end
			default: ;
		endcase
	endtask

	// Waits until every expected result is out, then for the pipeline to drain.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_address(logic [7:0] addr);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= addr;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slave_addr = addr;
		address_writes++;
	endtask

	// Result checker: each accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 0, int'(out_item));
			end else begin
				want_item = pending_results.pop_front();
				if (out_item.result_kind !== want_item.result_kind)
					report_mismatch("result_kind", want_item.result_kind, out_item.result_kind);
				if (out_item.digit_index !== want_item.digit_index)
					report_mismatch("digit_index", want_item.digit_index, out_item.digit_index);
				if (out_item.digit_segments !== want_item.digit_segments)
					report_mismatch("digit_segments", want_item.digit_segments,
						out_item.digit_segments);
				if (out_item.digit_blink !== want_item.digit_blink)
					report_mismatch("digit_blink", want_item.digit_blink, out_item.digit_blink);
				if (out_item.tx_byte !== want_item.tx_byte)
					report_mismatch("tx_byte", want_item.tx_byte, out_item.tx_byte);
				if (out_item.last !== want_item.last)
					report_mismatch("last", want_item.last, out_item.last);
			end
			results_checked <= results_checked + 1;
		end
	end

	// Receiver side: a random stall before taking each result item.
	initial begin
		int w;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			w = draw_wait();
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	task automatic test_read_after_reset();
		make_read(slave_addr);
		send_frame(3'b000);
		make_read(slave_addr);
		send_frame(3'b111);
	endtask

	task automatic test_write_digit_codes();
		digit_ctrl[7] = 8'h00; digit_val[7] = 8'd0;
		digit_ctrl[6] = 8'h00; digit_val[6] = 8'd15;
		digit_ctrl[5] = 8'h00; digit_val[5] = 8'd16;
		digit_ctrl[4] = 8'h00; digit_val[4] = 8'd17;
		digit_ctrl[3] = 8'h02; digit_val[3] = 8'hFF;
		digit_ctrl[2] = 8'h01; digit_val[2] = 8'h00;
		digit_ctrl[1] = 8'h03; digit_val[1] = 8'hFF;
		// High control bits are ignored: coded and steady.
		digit_ctrl[0] = 8'hFC; digit_val[0] = 8'd9;
		make_write(slave_addr);
		send_frame(3'b101);
	endtask

	task automatic test_rejected_frames();
		// A gap with nothing stored is rejected as an empty frame.
		send_gap(3'b010);
		send_flawed(FLAW_CRC);
		send_flawed(FLAW_ADDR);
		send_flawed(FLAW_FUNC);
		send_flawed(FLAW_LENGTH);
		send_flawed(FLAW_FIELD);
		send_flawed(FLAW_NOISE);
	endtask

	task automatic test_store_overflow();
		// A full store at the gap is judged as it stands.
		send_noise(STORE_DEPTH);
		send_gap(3'b001);
		send_flawed(FLAW_OVERFLOW);
	endtask

	task automatic test_address_setting();
		write_address(8'h00);
		make_read(8'h00);
		send_frame(3'b110);
		make_read(8'h01);
		send_frame(3'b110);
		write_address(8'hFF);
		random_digits();
		make_write(8'hFF);
		send_frame(3'b011);
		make_read(8'hFF);
		send_frame(3'b100);
		write_address(8'h01);
	endtask

	// Mostly good frames with random content, the rest flawed frames and noise.
	task automatic test_random_traffic();
		int first;
		int next_cfg;
		int pick;
		logic [7:0] addr;
		first = items_sent;
		next_cfg = 30;
		while (items_sent - first < RANDOM_ITEMS) begin
			// The first stretch runs with both sides at full rate.
			idle_off = (items_sent - first) < 20;
			if (items_sent - first >= next_cfg) begin
				write_address(8'($urandom_range(0, 255)));
				next_cfg += 30;
			end
			addr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : slave_addr;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				random_digits();
				make_write(addr);
				send_frame(3'($urandom_range(0, 7)));
			end else if (pick < 80) begin
				make_read(addr);
				send_frame(3'($urandom_range(0, 7)));
			end else begin
				send_flawed(frame_flaw_t'($urandom_range(0, 6)));
			end
		end
		idle_off = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		in_item = '0;
		out_ready = 1'b0;
		idle_off = 1'b0;
		mismatches = 0;
		results_checked = 0;
		items_sent = 0;
		frames_answered = 0;
		address_writes = 0;
		cycle_count = 0;
		slave_addr = 8'h01;
		rx_count = 0;
		for (int i = 0; i < STORE_DEPTH; i++) rx_store[i] = 8'h00;
		for (int d = 0; d < 8; d++) begin
			shown_segments[d] = 8'h00;
			shown_blink[d] = 1'b0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_read_after_reset();
		test_write_digit_codes();
		test_rejected_frames();
		test_store_overflow();
		test_address_setting();
		test_random_traffic();

		settle();
		if (pending_results.size() != 0)
			report_mismatch("results never delivered", pending_results.size(), 0);
		$display("run covered %0d input items and %0d answered frames, %0d results checked",
			items_sent, frames_answered, results_checked);
		$display("slave address written %0d times, extremes 0 and 255 included",
			address_writes);
		if (mismatches == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
